/* sv/brb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types, sizes and helper functions for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH    = 256;
    localparam int MAX_RUN  = 64;

    // The ring never grows past 256 bytes, whatever the store depth.
    localparam int RING_MAX = (DEPTH < 256) ? DEPTH : 256;
    localparam int PTR_W    = $clog2(RING_MAX);

    localparam int LEN_W    = 9;
    localparam int DATA_W   = 8;
    localparam int RUN_W    = 7;
    localparam int OFF_W    = 8;
    localparam int FILL_W   = 8;
    localparam int STATUS_W = 3;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(256);

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_GET   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_FLUSH = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_NOROOM = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_SHORT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GET,
        BK_PEEK
    } back_state_t;

    typedef struct packed {
        action_t             action;
        logic [DATA_W-1:0]   data_byte;
        logic [RUN_W-1:0]    run;
        logic [OFF_W-1:0]    peek_offset;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    function automatic logic [LEN_W-1:0] ring_len(input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] len;
        if (cap < LEN_W'(2))
            len = LEN_W'(2);
        else if (cap > LEN_W'(RING_MAX))
            len = LEN_W'(RING_MAX);
        else
            len = cap;
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp,
                                                 input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] f;
        if (wp >= rp)
            f = LEN_W'(wp) - LEN_W'(rp);
        else
            f = len + LEN_W'(wp) - LEN_W'(rp);
        return f;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [LEN_W-1:0] len);
        logic [PTR_W-1:0] n;
        if (LEN_W'(p) + LEN_W'(1) >= len)
            n = '0;
        else
            n = p + PTR_W'(1);
        return n;
    endfunction

    function automatic logic [RUN_W-1:0] clamp_run(input logic [RUN_W-1:0] rl);
        logic [RUN_W-1:0] r;
        if (rl == '0)
            r = RUN_W'(1);
        else if (rl > RUN_W'(MAX_RUN))
            r = RUN_W'(MAX_RUN);
        else
            r = rl;
        return r;
    endfunction

endpackage

/* sv/byte_ring_buffer_with_peek.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek
// Byte ring buffer with all-or-nothing put runs, get runs, peek and flush.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one command per
//   transaction: put one byte, get a run, peek at an offset, or flush.
//   Result channel (result_valid / result_stall) returns data_out, status,
//   last and fill_level; last marks the final result of a command.
//   capacity_we / capacity_wdata set the ring length and empty the ring;
//   write it only while no command is outstanding.
// Timing:
//   A two-entry command queue sits between the decoder and the executor.
//   Put, flush and error results pass through the queue entry and the
//   result register, one per cycle sustained while result_stall is low.
//   A peek also passes through the registered store read; the executor
//   takes no new command until its result is loaded. A get run takes the
//   same path for its first byte, then one byte per cycle while result_stall is low.
// Reset clears both pointers, any put run and sets capacity to 256. While
//   result_stall is high a valid result holds; the queue keeps taking
//   commands until it fills, then item_stall rises.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_peek (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            capacity_we,
    input  logic [brb_pkg::LEN_W-1:0]       capacity_wdata,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [1:0]                      action,
    input  logic [brb_pkg::DATA_W-1:0]      data_byte,
    input  logic [brb_pkg::RUN_W-1:0]       run_length,
    input  logic [brb_pkg::OFF_W-1:0]       peek_offset,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [brb_pkg::DATA_W-1:0]      data_out,
    output logic [brb_pkg::STATUS_W-1:0]    status,
    output logic                            last,
    output logic [brb_pkg::FILL_W-1:0]      fill_level
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    brb_pkg::cmd_t      q_cmd;
    brb_pkg::q_head_t   q_head;

    brb_front u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .action      (action),
        .data_byte   (data_byte),
        .run_length  (run_length),
        .peek_offset (peek_offset),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    brb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    brb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .head           (q_head),
        .pop            (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .data_out       (data_out),
        .status         (status),
        .last           (last),
        .fill_level     (fill_level)
    );

endmodule

/* sv/brb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_front
// Accepts input transactions, decodes the action and normalizes the run
// length, then pushes one command into the command queue.
// ----------------------------------------------------------------------------
module brb_front (
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    action,
    input  logic [brb_pkg::DATA_W-1:0]    data_byte,
    input  logic [brb_pkg::RUN_W-1:0]     run_length,
    input  logic [brb_pkg::OFF_W-1:0]     peek_offset,
    input  logic                          q_full,
    output logic                          q_push,
    output brb_pkg::cmd_t                 q_cmd
);

    brb_pkg::action_t act;

    always_comb
    begin
        unique case (action)
            2'd0:    act = brb_pkg::ACT_PUT;
            2'd1:    act = brb_pkg::ACT_GET;
            2'd2:    act = brb_pkg::ACT_PEEK;
            default: act = brb_pkg::ACT_FLUSH;
        endcase
    end

    always_comb
    begin
        q_cmd.action      = act;
        q_cmd.data_byte   = data_byte;
        q_cmd.run         = brb_pkg::clamp_run(run_length);
        q_cmd.peek_offset = peek_offset;
    end

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

endmodule

/* sv/brb_cmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_cmd_queue
// Short command FIFO between the front decoder and the back executor.
// ----------------------------------------------------------------------------
module brb_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brb_pkg::cmd_t       push_cmd,
    output logic                full,
    input  logic                pop,
    output brb_pkg::q_head_t    head
);

    brb_pkg::cmd_t                   entry_reg [brb_pkg::QDEPTH];
    logic [brb_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [brb_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [brb_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == brb_pkg::QPTR_W'(brb_pkg::QDEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + brb_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            if (rd_ptr_reg == brb_pkg::QPTR_W'(brb_pkg::QDEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + brb_pkg::QPTR_W'(1);
        end
        if (push && !pop)
            cnt_next = cnt_reg + brb_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - brb_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign full = (cnt_reg == brb_pkg::QCNT_W'(brb_pkg::QDEPTH));
    assign head = {(cnt_reg != '0), entry_reg[rd_ptr_reg]};

endmodule

/* sv/brb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_back
// Executes queued commands against the byte store and the ring pointers,
// and drives the result output register.
// ----------------------------------------------------------------------------
module brb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            capacity_we,
    input  logic [brb_pkg::LEN_W-1:0]       capacity_wdata,
    input  brb_pkg::q_head_t                head,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [brb_pkg::DATA_W-1:0]      data_out,
    output logic [brb_pkg::STATUS_W-1:0]    status,
    output logic                            last,
    output logic [brb_pkg::FILL_W-1:0]      fill_level
);

    logic [brb_pkg::DATA_W-1:0]  store_mem [brb_pkg::RING_MAX];
    logic [brb_pkg::DATA_W-1:0]  rd_data_reg;

    brb_pkg::back_state_t        state_reg, state_next;
    logic [brb_pkg::LEN_W-1:0]   cap_reg, cap_next;
    logic [brb_pkg::PTR_W-1:0]   wp_reg, wp_next;
    logic [brb_pkg::PTR_W-1:0]   rp_reg, rp_next;
    logic [brb_pkg::RUN_W-1:0]   put_rem_reg, put_rem_next;
    logic                        put_rej_reg, put_rej_next;
    logic [brb_pkg::RUN_W-1:0]   get_cnt_reg, get_cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic [brb_pkg::DATA_W-1:0]  data_out_reg, data_out_next;
    brb_pkg::status_t            status_reg, status_next;
    logic                        last_reg, last_next;
    logic [brb_pkg::FILL_W-1:0]  fill_reg, fill_next;

    logic [brb_pkg::LEN_W-1:0]   ring_cur;
    logic [brb_pkg::LEN_W-1:0]   fill_cur;
    logic [brb_pkg::LEN_W-1:0]   fill_after;
    logic [brb_pkg::LEN_W-1:0]   peek_sum;
    logic [brb_pkg::RUN_W-1:0]   rem_work;
    logic                        rej_work;
    logic                        out_free;
    logic                        out_load;
    logic                        mem_we;
    logic                        rd_en;
    logic [brb_pkg::PTR_W-1:0]   rd_addr;

    assign ring_cur = brb_pkg::ring_len(cap_reg);
    assign fill_cur = brb_pkg::fill_of(wp_reg, rp_reg, ring_cur);
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        peek_sum = brb_pkg::LEN_W'(rp_reg) + brb_pkg::LEN_W'(head.cmd.peek_offset);
        if (peek_sum >= ring_cur)
            peek_sum = peek_sum - ring_cur;
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        put_rem_next   = put_rem_reg;
        put_rej_next   = put_rej_reg;
        get_cnt_next   = get_cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        data_out_next  = data_out_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;
        fill_after     = fill_cur;
        rem_work       = put_rem_reg;
        rej_work       = put_rej_reg;
        out_load       = 1'b0;
        pop            = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = rp_reg;

        unique case (state_reg)
            brb_pkg::BK_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop           = 1'b1;
                    data_out_next = '0;
                    status_next   = brb_pkg::ST_OK;
                    last_next     = 1'b1;
                    unique case (head.cmd.action)
                        brb_pkg::ACT_PUT:
                        begin
                            // Check room only on the first byte of a run.
                            if (put_rem_reg == '0)
                            begin
                                rem_work = head.cmd.run;
                                rej_work = (fill_cur == ring_cur - brb_pkg::LEN_W'(1)) ||
                                           (ring_cur - brb_pkg::LEN_W'(1) - fill_cur <
                                            brb_pkg::LEN_W'(head.cmd.run));
                            end
                            if (rej_work)
                            begin
                                if (fill_cur == ring_cur - brb_pkg::LEN_W'(1))
                                    status_next = brb_pkg::ST_FULL;
                                else
                                    status_next = brb_pkg::ST_NOROOM;
                            end
                            else
                            begin
                                mem_we  = 1'b1;
                                wp_next = brb_pkg::ptr_inc(wp_reg, ring_cur);
                            end
                            rem_work = rem_work - brb_pkg::RUN_W'(1);
                            if (rem_work == '0)
                                rej_work = 1'b0;
                            put_rem_next = rem_work;
                            put_rej_next = rej_work;
                            out_load     = 1'b1;
                        end
                        brb_pkg::ACT_GET:
                        begin
                            if (fill_cur == '0)
                            begin
                                status_next = brb_pkg::ST_EMPTY;
                                out_load    = 1'b1;
                            end
                            else if (fill_cur < brb_pkg::LEN_W'(head.cmd.run))
                            begin
                                status_next = brb_pkg::ST_SHORT;
                                out_load    = 1'b1;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = rp_reg;
                                get_cnt_next = head.cmd.run;
                                state_next   = brb_pkg::BK_GET;
                            end
                        end
                        brb_pkg::ACT_PEEK:
                        begin
                            if (fill_cur == '0)
                            begin
                                status_next = brb_pkg::ST_EMPTY;
                                out_load    = 1'b1;
                            end
                            else if (brb_pkg::LEN_W'(head.cmd.peek_offset) >= fill_cur)
                            begin
                                status_next = brb_pkg::ST_SHORT;
                                out_load    = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = peek_sum[brb_pkg::PTR_W-1:0];
                                state_next = brb_pkg::BK_PEEK;
                            end
                        end
                        brb_pkg::ACT_FLUSH:
                        begin
                            wp_next      = '0;
                            rp_next      = '0;
                            put_rem_next = '0;
                            put_rej_next = 1'b0;
                            out_load     = 1'b1;
                        end
                    endcase
                end
            end
            brb_pkg::BK_GET:
            begin
                if (out_free)
                begin
                    // Hand out the fetched byte and prefetch the next one.
                    rp_next       = brb_pkg::ptr_inc(rp_reg, ring_cur);
                    rd_en         = 1'b1;
                    rd_addr       = rp_next;
                    data_out_next = rd_data_reg;
                    status_next   = brb_pkg::ST_OK;
                    last_next     = (get_cnt_reg == brb_pkg::RUN_W'(1));
                    out_load      = 1'b1;
                    get_cnt_next  = get_cnt_reg - brb_pkg::RUN_W'(1);
                    if (get_cnt_reg == brb_pkg::RUN_W'(1))
                        state_next = brb_pkg::BK_IDLE;
                end
            end
            brb_pkg::BK_PEEK:
            begin
                if (out_free)
                begin
                    data_out_next = rd_data_reg;
                    status_next   = brb_pkg::ST_OK;
                    last_next     = 1'b1;
                    out_load      = 1'b1;
                    state_next    = brb_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = brb_pkg::BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            fill_after     = brb_pkg::fill_of(wp_next, rp_next, ring_cur);
            fill_next      = fill_after[brb_pkg::FILL_W-1:0];
        end

        // A capacity write also empties the ring and drops any put run.
        if (capacity_we)
        begin
            cap_next     = capacity_wdata;
            wp_next      = '0;
            rp_next      = '0;
            put_rem_next = '0;
            put_rej_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brb_pkg::BK_IDLE;
            cap_reg       <= brb_pkg::CAP_RESET;
            wp_reg        <= '0;
            rp_reg        <= '0;
            put_rem_reg   <= '0;
            put_rej_reg   <= 1'b0;
            get_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            put_rem_reg   <= put_rem_next;
            put_rej_reg   <= put_rej_next;
            get_cnt_reg   <= get_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
        fill_reg     <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[wp_reg] <= head.cmd.data_byte;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign result_valid = out_valid_reg;
    assign data_out     = data_out_reg;
    assign status       = status_reg;
    assign last         = last_reg;
    assign fill_level   = fill_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cur < ring_cur)
        else $error("fill level reached ring length");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        brb_pkg::LEN_W'(wp_reg) < ring_cur)
        else $error("write pointer outside ring");

    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        brb_pkg::LEN_W'(rp_reg) < ring_cur)
        else $error("read pointer outside ring");

    a_get_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brb_pkg::BK_GET) |-> (get_cnt_reg != '0))
        else $error("get run active with zero bytes left");

    a_rej_run: assert property (@(posedge clk) disable iff (!rst_n)
        put_rej_reg |-> (put_rem_reg != '0))
        else $error("rejected put run with no bytes left");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == brb_pkg::BK_IDLE && head.valid))
        else $error("store written outside a put command");
`endif

endmodule
